// ----- sv/sdc_pkg.sv -----
`timescale 1ns / 1ps
package sdc_pkg;

  localparam int DRIVES_DEF = 2;
  localparam int SPD_DEF    = 1024;

  // Sector numbers, before and after interleave
  localparam int SEC_W = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic FUNC_WR = 1'b0;
  localparam logic FUNC_RD = 1'b1;

  localparam logic [2:0] PORT_DATA  = 3'd0;
  localparam logic [2:0] PORT_STAT  = 3'd1;
  localparam logic [2:0] PORT_RST_A = 3'd2;
  localparam logic [2:0] PORT_RST_B = 3'd4;

  localparam logic [2:0] REG_DRV_PRESENT = 3'd0;
  localparam logic [2:0] REG_WR_PROTECT  = 3'd1;
  localparam logic [2:0] REG_SEC_COUNT   = 3'd2;
  localparam logic [2:0] REG_SEC_PER_CL  = 3'd3;
  localparam logic [2:0] REG_NEW_ADDR    = 3'd4;
  localparam logic [2:0] REG_ILV_MASK    = 3'd5;
  localparam logic [2:0] REG_ILV_FACTOR  = 3'd6;

  localparam logic [10:0] SEC_COUNT_RST = 11'd640;
  localparam logic [5:0]  SPC_RST       = 6'd1;

  localparam logic [2:0] PH_K0 = 3'd0;
  localparam logic [2:0] PH_K3 = 3'd3;
  localparam logic [2:0] PH_UL = 3'd4;
  localparam logic [2:0] PH_DL = 3'd5;

  localparam int K0_RD = 0;
  localparam int K0_DL = 1;
  localparam int K0_UL = 2;
  localparam int K0_WR = 3;

  localparam logic [7:0] STAT_NOTRDY = 8'h80;
  localparam logic [7:0] STAT_READY  = 8'h01;
  localparam logic [7:0] STAT_IDLE   = 8'h80;
  localparam logic [7:0] PRI_ERR     = 8'h08;
  localparam logic [7:0] PRI_WP      = 8'h80;
  localparam logic [7:0] AUX_NODRV   = 8'h80;
  localparam logic [7:0] AUX_RANGE   = 8'h10;
  localparam logic [7:0] AUX_WP      = 8'h40;
  localparam logic [7:0] RD_UNUSED   = 8'hFF;
  localparam logic [2:0] NR_INIT     = 3'd4;

  typedef struct packed {
    logic take;
    logic dl_emit;
    logic sec_ld;
    logic chk;
    logic start_dl;
    logic start_ul;
    logic wp_fail;
    logic end_run;
    logic ilv_ld;
    logic mod_step;
    logic cp_in;
    logic cp_out;
  } sdc_cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       dl_go;
    logic       k3_go;
    logic       ul_last;
    logic       dl_end;
    logic       chk_ok;
    logic [3:0] k0;
    logic       wp;
    logic       ofs_ok;
    logic       cp_done;
  } sdc_stat_t;

endpackage

// ----- sv/sdc_ctrl.sv -----
`timescale 1ns / 1ps
module sdc_ctrl
  import sdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sdc_stat_t st,
  output sdc_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_DLRD  = 10'b00_0000_0010,
    S_CSEC  = 10'b00_0000_0100,
    S_CHK   = 10'b00_0000_1000,
    S_RUN   = 10'b00_0001_0000,
    S_SEC   = 10'b00_0010_0000,
    S_ILV   = 10'b00_0100_0000,
    S_MOD   = 10'b00_1000_0000,
    S_CPIN  = 10'b01_0000_0000,
    S_CPOUT = 10'b10_0000_0000
  } sdc_state_t;

  sdc_state_t state_r, state_nxt;
  logic acc;

  assign in_ready = (state_r == S_IDLE) && st.out_free;
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.take = acc;
        if (acc) begin
          if (st.dl_go) state_nxt = S_DLRD;
          else if (st.k3_go) state_nxt = S_CSEC;
          else if (st.ul_last) state_nxt = S_RUN;
        end
      end
      S_DLRD: begin
        cmd.dl_emit = 1'b1;
        state_nxt = st.dl_end ? S_RUN : S_IDLE;
      end
      S_CSEC: begin
        cmd.sec_ld = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        state_nxt = st.chk_ok ? S_RUN : S_IDLE;
      end
      S_RUN: begin
        if (st.k0[K0_RD]) begin
          state_nxt = S_SEC;
        end else if (st.k0[K0_DL]) begin
          cmd.start_dl = 1'b1;
          state_nxt = S_IDLE;
        end else if (st.k0[K0_UL]) begin
          cmd.start_ul = 1'b1;
          state_nxt = S_IDLE;
        end else if (st.k0[K0_WR] && st.wp) begin
          cmd.wp_fail = 1'b1;
          state_nxt = S_IDLE;
        end else if (st.k0[K0_WR]) begin
          state_nxt = S_SEC;
        end else begin
          cmd.end_run = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SEC: begin
        cmd.sec_ld = 1'b1;
        state_nxt = S_ILV;
      end
      S_ILV: begin
        cmd.ilv_ld = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (st.ofs_ok) state_nxt = st.k0[K0_RD] ? S_CPIN : S_CPOUT;
        else cmd.mod_step = 1'b1;
      end
      S_CPIN: begin
        cmd.cp_in = 1'b1;
        if (st.cp_done) state_nxt = S_RUN;
      end
      S_CPOUT: begin
        cmd.cp_out = 1'b1;
        if (st.cp_done) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Copies and address steps only run with the host side closed
  a_busy_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("input open outside idle");
  a_copy_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CPOUT && st.cp_done) |=> (state_r == S_IDLE))
    else $error("copy to medium did not finish");
  a_chk_src: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> ($past(state_r) == S_CSEC))
    else $error("check without fresh sector");

endmodule

// ----- sv/sdc_dp.sv -----
`timescale 1ns / 1ps
module sdc_dp
  import sdc_pkg::*;
#(
  parameter int DRIVES            = DRIVES_DEF,
  parameter int SECTORS_PER_DRIVE = SPD_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_func,
  input  logic [2:0]            in_port,
  input  logic [7:0]            in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_read_data,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  sdc_cmd_t              cmd,
  output sdc_stat_t             st
);

  localparam int MED_DEPTH = DRIVES * SECTORS_PER_DRIVE * 256;
  localparam int MED_AW    = $clog2(MED_DEPTH);
  localparam int MSEC_W    = MED_AW - 8;
  localparam logic [SEC_W-1:0] SPD_C = SEC_W'(SECTORS_PER_DRIVE);

  logic [7:0]  drv_r, drv_nxt, wp_r, wp_nxt, imask_r, imask_nxt, ifac_r, ifac_nxt;
  logic [10:0] scnt_r, scnt_nxt;
  logic [5:0]  spc_r, spc_nxt;
  logic        newa_r, newa_nxt;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  cmdb_r [4];
  logic [7:0]  cmdb_nxt [4];
  logic [7:0]  prim_r, prim_nxt, aux_r, aux_nxt;
  logic        dl_act_r, dl_act_nxt;
  logic [7:0]  dl_idx_r, dl_idx_nxt, ul_idx_r, ul_idx_nxt;
  logic [2:0]  nr_r, nr_nxt;
  logic [SEC_W-1:0] sec_r, sec_nxt, ofs_r, ofs_nxt;
  logic [8:0]  cp_r, cp_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r, out_data_nxt;

  logic [7:0] buf_mem [1024];
  logic [7:0] med_mem [MED_DEPTH];
  logic [7:0] buf_q_r, med_q_r;

  logic [2:0]  drv;
  logic [2:0]  drv_eff;
  logic [1:0]  bsel;
  logic        drv_bad;
  logic [SEC_W-1:0] lim, cl_base, cl_sec;
  logic [15:0] iprod;
  logic [8:0]  cp_m1;
  logic [MSEC_W-1:0] msec;
  logic        ul_wr;
  logic        buf_we, med_we;
  logic [9:0]  buf_wa, buf_ra;
  logic [7:0]  buf_wd;
  logic [MED_AW-1:0] med_wa, med_ra;

  assign drv     = cmdb_r[1][2:0];
  assign bsel    = cmdb_r[1][7:6];
  assign drv_bad = (32'(drv) >= DRIVES) || !drv_r[drv];
  assign drv_eff = (32'(drv) >= DRIVES) ? 3'd0 : drv;
  assign lim     = (SEC_W'(scnt_r) > SPD_C) ? SPD_C : SEC_W'(scnt_r);
  assign cl_base = SEC_W'({cmdb_r[2], 3'b000}) + SEC_W'(cmdb_r[3][7:5]);
  assign cl_sec  = cl_base * SEC_W'(spc_r) + SEC_W'(cmdb_r[3][4:0]);
  assign iprod   = sec_r[7:0] * ifac_r;
  assign cp_m1   = cp_r - 9'd1;
  assign msec    = MSEC_W'(32'(drv_eff) * SECTORS_PER_DRIVE) + MSEC_W'(ofs_r);
  assign ul_wr   = cmd.take && (in_func == FUNC_WR) && (in_port == PORT_DATA)
                   && (phase_r == PH_UL);

  always_comb begin
    st.out_free = !out_valid_r || out_ready;
    st.dl_go    = (in_func == FUNC_RD) && (in_port == PORT_DATA) && dl_act_r;
    st.k3_go    = (in_func == FUNC_WR) && (in_port == PORT_DATA) && (phase_r == PH_K3);
    st.ul_last  = (in_func == FUNC_WR) && (in_port == PORT_DATA) && (phase_r == PH_UL)
                  && (ul_idx_r == 8'hFF);
    st.dl_end   = !dl_act_r;
    st.chk_ok   = !drv_bad && (sec_r < lim);
    st.k0       = cmdb_r[0][3:0];
    st.wp       = wp_r[drv];
    st.ofs_ok   = ofs_r < SPD_C;
    st.cp_done  = cp_r[8];
  end

  always_comb begin
    drv_nxt = drv_r; wp_nxt = wp_r; scnt_nxt = scnt_r; spc_nxt = spc_r;
    newa_nxt = newa_r; imask_nxt = imask_r; ifac_nxt = ifac_r;
    phase_nxt = phase_r; cmdb_nxt = cmdb_r; prim_nxt = prim_r; aux_nxt = aux_r;
    dl_act_nxt = dl_act_r; dl_idx_nxt = dl_idx_r; ul_idx_nxt = ul_idx_r;
    nr_nxt = nr_r; sec_nxt = sec_r; ofs_nxt = ofs_r; cp_nxt = cp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt = out_data_r;

    if (cfg_valid) begin
      case (cfg_index)
        REG_DRV_PRESENT: drv_nxt   = cfg_data[7:0];
        REG_WR_PROTECT:  wp_nxt    = cfg_data[7:0];
        REG_SEC_COUNT:   scnt_nxt  = cfg_data;
        REG_SEC_PER_CL:  spc_nxt   = cfg_data[5:0];
        REG_NEW_ADDR:    newa_nxt  = cfg_data[0];
        REG_ILV_MASK:    imask_nxt = cfg_data[7:0];
        REG_ILV_FACTOR:  ifac_nxt  = cfg_data[7:0];
        default: ;
      endcase
    end

    if (cmd.take) begin
      if (in_func == FUNC_RD) begin
        case (in_port)
          PORT_DATA: begin
            if (dl_act_r) begin
              dl_idx_nxt = dl_idx_r + 8'd1;
              if (dl_idx_r == 8'hFF) dl_act_nxt = 1'b0;
            end else begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = aux_r;
            end
          end
          PORT_STAT: begin
            out_valid_nxt = 1'b1;
            if (nr_r != 3'd0) begin
              nr_nxt       = nr_r - 3'd1;
              out_data_nxt = STAT_NOTRDY;
            end else begin
              out_data_nxt = STAT_READY | prim_r | ((phase_r == PH_K0) ? STAT_IDLE : 8'h00);
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = RD_UNUSED;
          end
        endcase
      end else if (in_port == PORT_DATA) begin
        if (phase_r < PH_K3) begin
          prim_nxt = '0;
          aux_nxt  = '0;
          cmdb_nxt[phase_r[1:0]] = in_value;
          phase_nxt = phase_r + 3'd1;
        end else if (phase_r == PH_K3) begin
          prim_nxt = '0;
          aux_nxt  = '0;
          cmdb_nxt[3] = in_value;
          phase_nxt = PH_K0;
        end else if (phase_r == PH_UL) begin
          ul_idx_nxt = ul_idx_r + 8'd1;
        end
      end else if (in_port inside {PORT_RST_A, PORT_RST_B}) begin
        phase_nxt  = PH_K0;
        prim_nxt   = '0;
        aux_nxt    = '0;
        dl_act_nxt = 1'b0;
        dl_idx_nxt = '0;
        ul_idx_nxt = '0;
        nr_nxt     = NR_INIT;
      end
    end

    if (cmd.dl_emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = buf_q_r;
    end
    if (cmd.sec_ld) sec_nxt = newa_r ? SEC_W'({cmdb_r[2], cmdb_r[3]}) : cl_sec;
    if (cmd.chk) begin
      if (drv_bad) begin
        prim_nxt = PRI_ERR;
        aux_nxt  = AUX_NODRV;
      end else if (sec_r >= lim) begin
        prim_nxt = PRI_ERR;
        aux_nxt  = AUX_RANGE;
      end
    end
    if (cmd.start_dl) begin
      dl_act_nxt = 1'b1;
      dl_idx_nxt = '0;
      phase_nxt  = PH_DL;
      cmdb_nxt[0][K0_DL] = 1'b0;
    end
    if (cmd.start_ul) begin
      phase_nxt  = PH_UL;
      ul_idx_nxt = '0;
      cmdb_nxt[0][K0_UL] = 1'b0;
    end
    if (cmd.wp_fail) begin
      prim_nxt  = PRI_WP;
      aux_nxt   = AUX_WP;
      phase_nxt = PH_K0;
      cmdb_nxt[0][K0_WR] = 1'b0;
    end
    if (cmd.end_run) phase_nxt = PH_K0;
    if (cmd.ilv_ld) begin
      ofs_nxt = (sec_r & ~SEC_W'(imask_r)) | SEC_W'(iprod[7:0] & imask_r);
      cp_nxt  = '0;
    end
    if (cmd.mod_step) ofs_nxt = ofs_r - SPD_C;
    if (cmd.cp_in || cmd.cp_out) cp_nxt = cp_r + 9'd1;
    if (cmd.cp_in && cp_r[8]) cmdb_nxt[0][K0_RD] = 1'b0;
    if (cmd.cp_out && cp_r[8]) begin
      cmdb_nxt[0][K0_WR] = 1'b0;
      phase_nxt = PH_K0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drv_r <= '0; wp_r <= '0; scnt_r <= SEC_COUNT_RST; spc_r <= SPC_RST;
      newa_r <= 1'b0; imask_r <= '0; ifac_r <= '0;
      phase_r <= PH_K0;
      cmdb_r <= '{default: 8'h00};
      prim_r <= '0; aux_r <= '0;
      dl_act_r <= 1'b0; dl_idx_r <= '0; ul_idx_r <= '0;
      nr_r <= NR_INIT;
      cp_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      drv_r <= drv_nxt; wp_r <= wp_nxt; scnt_r <= scnt_nxt; spc_r <= spc_nxt;
      newa_r <= newa_nxt; imask_r <= imask_nxt; ifac_r <= ifac_nxt;
      phase_r <= phase_nxt;
      cmdb_r <= cmdb_nxt;
      prim_r <= prim_nxt; aux_r <= aux_nxt;
      dl_act_r <= dl_act_nxt; dl_idx_r <= dl_idx_nxt; ul_idx_r <= ul_idx_nxt;
      nr_r <= nr_nxt;
      cp_r <= cp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sec_r      <= sec_nxt;
    ofs_r      <= ofs_nxt;
    out_data_r <= out_data_nxt;
  end

  // Buffer port: host bytes or medium data in, host stream or medium copy out
  assign buf_we = ul_wr || (cmd.cp_in && (cp_r != 9'd0));
  assign buf_wa = ul_wr ? {bsel, ul_idx_r} : {bsel, cp_m1[7:0]};
  assign buf_wd = ul_wr ? in_value : med_q_r;
  assign buf_ra = cmd.cp_out ? {bsel, cp_r[7:0]} : {bsel, dl_idx_r};

  assign med_we = cmd.cp_out && (cp_r != 9'd0);
  assign med_wa = {msec, cp_m1[7:0]};
  assign med_ra = {msec, cp_r[7:0]};

  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[buf_wa] <= buf_wd;
    buf_q_r <= buf_mem[buf_ra];
  end

  always_ff @(posedge clk) begin
    if (med_we) med_mem[med_wa] <= buf_q_r;
    med_q_r <= med_mem[med_ra];
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  a_dl_phase: assert property (@(posedge clk) disable iff (!rst_n)
    dl_act_r |-> (phase_r == PH_DL))
    else $error("stream active outside download phase");
  a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dl_emit |=> out_valid_r)
    else $error("stream byte lost");
  a_mod_need: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mod_step |-> (ofs_r >= SPD_C))
    else $error("wrap step on in-range offset");
  a_nr_range: assert property (@(posedge clk) disable iff (!rst_n)
    nr_r <= NR_INIT)
    else $error("not-ready count out of range");

endmodule

// ----- sv/sector_disk_controller_port_top.sv -----
`timescale 1ns / 1ps
// Sector disk controller seen through an 8-bit port bus. Each beat on the in_
// channel is one port access (in_func 0 write, 1 read); every read returns one
// beat on out_, writes return nothing. A port 0 read that streams a buffer byte
// goes through the registered buffer RAM read. The fourth command byte passes
// through the sector address and range check steps, then runs the command: each
// sector transfer between medium and buffer holds the bus closed while its 256
// byte moves pass through the registered RAM ports, after the interleave wrap,
// one subtract of the drive size per cycle. The last host byte of an upload or
// stream starts the remaining command steps the same way. Configuration writes
// are taken every cycle.
module sector_disk_controller_port_top
  import sdc_pkg::*;
#(
  parameter int DRIVES            = DRIVES_DEF,
  parameter int SECTORS_PER_DRIVE = SPD_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_func,
  input  logic [2:0]            in_port,
  input  logic [7:0]            in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_read_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sdc_cmd_t  cmd;
  sdc_stat_t st;

  // Registers are plain flops: accept a write beat every cycle
  assign cfg_ready = 1'b1;

  // Sequencer: accept beats, walk the command steps, drive the copies
  sdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: port state, address math, buffer and medium RAMs, output beat
  sdc_dp #(
    .DRIVES            (DRIVES),
    .SECTORS_PER_DRIVE (SECTORS_PER_DRIVE)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_func       (in_func),
    .in_port       (in_port),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .st            (st)
  );

endmodule

// ----- tb/sdc_checker.sv -----
`timescale 1ns / 1ps
module sdc_checker
  import sdc_pkg::*;
#(
  parameter int DRIVES            = DRIVES_DEF,
  parameter int SECTORS_PER_DRIVE = SPD_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_func,
  input  logic [2:0]            in_port,
  input  logic [7:0]            in_value,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            out_read_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  logic [7:0]  r_present, r_wp, r_mask, r_fac;
  logic [10:0] r_count;
  logic [5:0]  r_spc;
  logic        r_new;

  logic [2:0] ph;
  logic [7:0] cmd [0:3];
  logic [7:0] pri, aux;
  logic       dl_on;
  logic [8:0] dl_idx, ul_idx;
  logic [2:0] nr_cnt;
  logic [7:0] bufs [0:1023];
  logic [7:0] disk [0:DRIVES*SECTORS_PER_DRIVE*256-1];
  logic [7:0] read_q [$];

  assign pending = read_q.size();

  function automatic int unsigned sector_num();
    int unsigned k2, k3;
    k2 = 32'(cmd[2]);
    k3 = 32'(cmd[3]);
    if (r_new) return k2 * 256 + k3;
    return (k2 * 8 + (k3 >> 5)) * r_spc + (k3 & 31);
  endfunction

  function automatic int unsigned disk_base();
    int unsigned s, m, d;
    s = sector_num();
    m = 32'(r_mask);
    s = (s & ~m) | ((s * r_fac) & m);
    s = s % SECTORS_PER_DRIVE;
    d = 32'(cmd[1][2:0]);
    if (d >= DRIVES) d = 0;
    return (d * SECTORS_PER_DRIVE + s) * 256;
  endfunction

  function automatic int unsigned buf_base();
    return cmd[1][7:6] * 256;
  endfunction

  // Walk the remaining command bits; stop at a host transfer.
  function automatic void continue_command();
    int unsigned db, bb;
    db = disk_base();
    bb = buf_base();
    if (cmd[0][K0_RD]) begin
      for (int i = 0; i < 256; i++) bufs[bb + i] = disk[db + i];
      cmd[0][K0_RD] = 1'b0;
    end
    if (cmd[0][K0_DL]) begin
      dl_on = 1'b1;
      dl_idx = '0;
      ph = PH_DL;
      cmd[0][K0_DL] = 1'b0;
      return;
    end
    if (cmd[0][K0_UL]) begin
      ph = PH_UL;
      ul_idx = '0;
      cmd[0][K0_UL] = 1'b0;
      return;
    end
    if (cmd[0][K0_WR]) begin
      if (r_wp[cmd[1][2:0]]) begin
        pri = PRI_WP;
        aux = AUX_WP;
      end else begin
        for (int i = 0; i < 256; i++) disk[db + i] = bufs[bb + i];
      end
      cmd[0][K0_WR] = 1'b0;
    end
    ph = PH_K0;
  endfunction

  function automatic void port_clear();
    ph = PH_K0;
    pri = '0;
    aux = '0;
    dl_on = 1'b0;
    dl_idx = '0;
    ul_idx = '0;
    nr_cnt = NR_INIT;
  endfunction

  function automatic void data_write(logic [7:0] v);
    int unsigned lim, d;
    if (ph < PH_K3) begin
      pri = '0;
      aux = '0;
      cmd[ph[1:0]] = v;
      ph = ph + 3'd1;
    end else if (ph == PH_K3) begin
      pri = '0;
      aux = '0;
      cmd[3] = v;
      ph = PH_K0;
      lim = (32'(r_count) > SECTORS_PER_DRIVE) ? SECTORS_PER_DRIVE : 32'(r_count);
      d = 32'(cmd[1][2:0]);
      if (d >= DRIVES || !r_present[d]) begin
        pri = PRI_ERR;
        aux = AUX_NODRV;
      end else if (sector_num() >= lim) begin
        pri = PRI_ERR;
        aux = AUX_RANGE;
      end else begin
        continue_command();
      end
    end else if (ph == PH_UL) begin
      bufs[buf_base() + ul_idx[7:0]] = v;
      ul_idx = ul_idx + 9'd1;
      if (ul_idx >= 256) continue_command();
    end
  endfunction

  function automatic logic [7:0] port_read(logic [2:0] p);
    logic [7:0] r;
    r = RD_UNUSED;
    if (p == PORT_DATA) begin
      if (dl_on) begin
        r = bufs[buf_base() + dl_idx[7:0]];
        dl_idx = dl_idx + 9'd1;
        if (dl_idx >= 256) begin
          dl_on = 1'b0;
          dl_idx = '0;
          continue_command();
        end
      end else begin
        r = aux;
      end
    end else if (p == PORT_STAT) begin
      if (nr_cnt != 0) begin
        nr_cnt = nr_cnt - 3'd1;
        r = STAT_NOTRDY;
      end else begin
        r = STAT_READY | pri | ((ph == PH_K0) ? STAT_IDLE : 8'h00);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      errors = 0;
      r_present = '0;
      r_wp = '0;
      r_count = SEC_COUNT_RST;
      r_spc = SPC_RST;
      r_new = 1'b0;
      r_mask = '0;
      r_fac = '0;
      for (int i = 0; i < 4; i++) cmd[i] = '0;
      port_clear();
      read_q.delete();
    end else begin
      // compare first: a beat taken this edge cannot answer a read taken now
      if (out_valid && out_ready) begin
        if (read_q.size() == 0) begin
          if (errors < 10) $display("sdc_checker: unexpected read beat %02h", out_read_data);
          errors++;
        end else begin
          if (out_read_data !== read_q[0]) begin
            if (errors < 10)
              $display("sdc_checker: read_data expected %02h got %02h", read_q[0],
                       out_read_data);
            errors++;
          end
          void'(read_q.pop_front());
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DRV_PRESENT: r_present = cfg_data[7:0];
          REG_WR_PROTECT:  r_wp = cfg_data[7:0];
          REG_SEC_COUNT:   r_count = cfg_data;
          REG_SEC_PER_CL:  r_spc = cfg_data[5:0];
          REG_NEW_ADDR:    r_new = cfg_data[0];
          REG_ILV_MASK:    r_mask = cfg_data[7:0];
          REG_ILV_FACTOR:  r_fac = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_func == FUNC_RD) begin
          read_q.push_back(port_read(in_port));
        end else if (in_port == PORT_DATA) begin
          data_write(in_value);
        end else if (in_port == PORT_RST_A || in_port == PORT_RST_B) begin
          port_clear();
        end
      end
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import sdc_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid, in_ready, in_func;
  logic [2:0]            in_port;
  logic [7:0]            in_value;
  logic                  out_valid, out_ready;
  logic [7:0]            out_read_data;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors, pending;

  // Shadow of the settings and of what holds defined data. Used to keep the
  // stimulus off bytes that were never written and to follow which commands run.
  logic [7:0]  sh_present, sh_wp;
  int unsigned sh_count, sh_spc, sh_new, sh_mask, sh_fac;
  bit [255:0]  buf_full [0:3];
  bit          sec_ok [0:2*1024-1];

  int beats_sent;
  bit calm;        // no idling on either side
  bit hold_req;    // ask the result side for one long hold-off

  sector_disk_controller_port_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_port(in_port), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_read_data(out_read_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sdc_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_port(in_port), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_read_data(out_read_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Result side: random stall bursts, one long hold-off on request, none when calm.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (rst_n && !calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Offer one beat and hold it until taken; an idle burst may come first.
  task automatic send_beat(input logic f, input logic [2:0] p, input logic [7:0] v);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_port  <= p;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic port_reset_beat();
    send_beat(FUNC_WR, $urandom_range(0, 1) ? PORT_RST_A : PORT_RST_B, 8'($urandom));
  endtask

  // Drop valid, drain every read, then let any sector copy finish.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] p, input logic [7:0] w, input int unsigned c,
                            input int unsigned spc, input int unsigned na,
                            input int unsigned m, input int unsigned f);
    logic [CFG_DATA_W-1:0] vals [0:6];
    logic [CFG_IDX_W-1:0]  idx  [0:6];
    sh_present = p;
    sh_wp = w;
    sh_count = c;
    sh_spc = spc;
    sh_new = na;
    sh_mask = m;
    sh_fac = f;
    idx[0] = REG_DRV_PRESENT; vals[0] = CFG_DATA_W'(p);
    idx[1] = REG_WR_PROTECT;  vals[1] = CFG_DATA_W'(w);
    idx[2] = REG_SEC_COUNT;   vals[2] = CFG_DATA_W'(c);
    idx[3] = REG_SEC_PER_CL;  vals[3] = CFG_DATA_W'(spc);
    idx[4] = REG_NEW_ADDR;    vals[4] = CFG_DATA_W'(na);
    idx[5] = REG_ILV_MASK;    vals[5] = CFG_DATA_W'(m);
    idx[6] = REG_ILV_FACTOR;  vals[6] = CFG_DATA_W'(f);
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic int unsigned sector_of(logic [7:0] k2, logic [7:0] k3);
    if (sh_new) return k2 * 256 + k3;
    return (k2 * 8 + (k3 >> 5)) * sh_spc + (k3 & 31);
  endfunction

  function automatic int unsigned slot_of(logic [7:0] k1, logic [7:0] k2, logic [7:0] k3);
    int unsigned s;
    s = sector_of(k2, k3);
    s = (s & ~sh_mask) | ((s * sh_fac) & sh_mask);
    return k1[0] * 1024 + (s % 1024);
  endfunction

  // Send one four-byte command and carry out the host side of its transfers.
  task automatic issue_cmd(input logic [7:0] k0, k1, k2, k3, input bit abort);
    int unsigned d, lim, cut_dl, cut_ul;
    logic [1:0] b;
    send_beat(FUNC_WR, PORT_DATA, k0);
    send_beat(FUNC_WR, PORT_DATA, k1);
    send_beat(FUNC_WR, PORT_DATA, k2);
    send_beat(FUNC_WR, PORT_DATA, k3);
    d = 32'(k1[2:0]);
    b = k1[7:6];
    lim = (sh_count > 1024) ? 1024 : sh_count;
    if (d >= 2 || !sh_present[d] || sector_of(k2, k3) >= lim) return;
    cut_dl = (abort && $urandom_range(0, 1)) ? $urandom_range(0, 255) : 256;
    cut_ul = abort ? $urandom_range(0, 255) : 256;
    if (k0[K0_RD]) buf_full[b] = '1;
    if (k0[K0_DL]) begin
      for (int n = 0; n < 256; n++) begin
        if (n == cut_dl) begin
          port_reset_beat();
          return;
        end
        // port 0 writes in a stream are dropped by the block
        if ($urandom_range(0, 15) == 0) send_beat(FUNC_RD, PORT_STAT, 8'($urandom));
        if ($urandom_range(0, 31) == 0) send_beat(FUNC_WR, PORT_DATA, 8'($urandom));
        send_beat(FUNC_RD, PORT_DATA, 8'($urandom));
      end
    end
    if (k0[K0_UL]) begin
      for (int n = 0; n < 256; n++) begin
        if (n == cut_ul) begin
          port_reset_beat();
          return;
        end
        if ($urandom_range(0, 15) == 0) send_beat(FUNC_RD, PORT_STAT, 8'($urandom));
        if ($urandom_range(0, 31) == 0) send_beat(FUNC_RD, PORT_DATA, 8'($urandom));
        send_beat(FUNC_WR, PORT_DATA, 8'($urandom));
        buf_full[b][n] = 1'b1;
      end
    end
    if (k0[K0_WR] && !sh_wp[d]) sec_ok[slot_of(k1, k2, k3)] = 1'b1;
  endtask

  // Random command, with steps that would touch undefined data dropped.
  task automatic random_cmd();
    logic [7:0] k0, k1, k2, k3;
    logic [1:0] b;
    bit full;
    k0 = 8'($urandom);
    k1 = 8'($urandom);
    if ($urandom_range(0, 7) != 0) k1[2:0] = 3'($urandom_range(0, 1));
    k2 = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0;
    k3 = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    b = k1[7:6];
    if (k1[2:0] < 2) begin
      if (k0[K0_RD] && !sec_ok[slot_of(k1, k2, k3)]) k0[K0_RD] = 1'b0;
      full = (buf_full[b] == '1) || k0[K0_RD];
      if (k0[K0_DL] && !full) k0[K0_DL] = 1'b0;
      full = full || k0[K0_UL];
      if (k0[K0_WR] && !full) k0[K0_WR] = 1'b0;
    end
    issue_cmd(k0, k1, k2, k3, $urandom_range(0, 7) == 0);
  endtask

  task automatic random_op();
    int unsigned r;
    logic [2:0] p;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      random_cmd();
    end else if (r < 65) begin
      // broken command: a few bytes, then a port reset
      repeat ($urandom_range(1, 3)) send_beat(FUNC_WR, PORT_DATA, 8'($urandom));
      port_reset_beat();
    end else if (r < 85) begin
      send_beat(FUNC_RD, 3'($urandom), 8'($urandom));
    end else begin
      p = 3'($urandom_range(1, 7));
      send_beat(FUNC_WR, p, 8'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_WR;
    in_port = '0;
    in_value = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    beats_sent = 0;
    sh_present = '0;
    sh_wp = '0;
    sh_count = SEC_COUNT_RST;
    sh_spc = SPC_RST;
    sh_new = 0;
    sh_mask = 0;
    sh_fac = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: not-ready replies, status, unused ports, resets, no drive.
    repeat (5) send_beat(FUNC_RD, PORT_STAT, 8'h00);
    send_beat(FUNC_RD, PORT_DATA, 8'hFF);
    send_beat(FUNC_RD, 3'd7, 8'h00);
    send_beat(FUNC_WR, 3'd3, 8'hA5);
    issue_cmd(8'h0F, 8'h00, 8'h00, 8'h00, 1'b0);
    send_beat(FUNC_RD, PORT_DATA, 8'h00);
    send_beat(FUNC_RD, PORT_STAT, 8'h00);
    send_beat(FUNC_WR, PORT_RST_A, 8'h00);
    send_beat(FUNC_RD, PORT_STAT, 8'h00);
    send_beat(FUNC_WR, PORT_RST_B, 8'hFF);
    wait_quiet();
    // sector count of one: sector 5 is out of range
    set_config(8'h03, 8'h00, 1, 1, 0, 0, 0);
    issue_cmd(8'h01, 8'h00, 8'h00, 8'h05, 1'b0);
    send_beat(FUNC_RD, PORT_DATA, 8'h00);
    send_beat(FUNC_RD, PORT_STAT, 8'h00);

    // Random phases, each under its own settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      wait_quiet();
      case (ph)
        0: set_config(8'h03, 8'h00, 640, 1, 0, 0, 0);
        1: set_config(8'hFF, 8'h02, 1024, 32, 1, 255, 255);
        2: set_config(8'h01, 8'hFF, 0, 63, 0, 0, 1);
        3: set_config(8'h03, 8'h00, 2047, $urandom_range(1, 32), 0, 7, 3);
        default: set_config(8'($urandom), 8'($urandom_range(0, 3)),
                            $urandom_range(0, 2047), $urandom_range(1, 32),
                            $urandom_range(0, 1), $urandom_range(0, 255),
                            $urandom_range(0, 255));
      endcase
      if (ph == 5) calm = 1'b1;
      if (ph == 1) begin
        // long hold-off on results while status reads keep coming
        hold_req = 1'b1;
        repeat (40) send_beat(FUNC_RD, PORT_STAT, 8'($urandom));
      end
      while (beats_sent < 25 + (ph + 1) * 250) random_op();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
